// File: design/pfs_pkg.sv
// shared constants, types and state codes for the prime factor summary unit
// no dependencies

package pfs_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((2 * VALUE_WIDTH + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } state_e;

  // request into the shared divider
  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

endpackage

// File: design/pfs_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on pfs_pkg

module pfs_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfs_pkg::div_req_t req_i,
  output pfs_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [pfs_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  pfs_pkg::value_t               rem_q, rem_d;
  pfs_pkg::value_t               quo_q, quo_d;
  pfs_pkg::value_t               dvs_q, dvs_d;

  logic [pfs_pkg::VALUE_WIDTH:0] rem_sh;
  logic [pfs_pkg::VALUE_WIDTH:0] diff;
  logic                          fits;

  assign rem_sh = {rem_q, quo_q[pfs_pkg::VALUE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = ~diff[pfs_pkg::VALUE_WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = pfs_pkg::CNT_W'(pfs_pkg::VALUE_WIDTH);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[pfs_pkg::VALUE_WIDTH-1:0] : rem_sh[pfs_pkg::VALUE_WIDTH-1:0];
      quo_d = {quo_q[pfs_pkg::VALUE_WIDTH-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pfs_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: design/prime_factor_summary_unit.sv
// top level of the prime factor summary unit: sequencer, result register
// depends on pfs_pkg and pfs_divider

// Factors one unsigned value per item by trial division and returns its
// largest prime factor and the sum of its distinct prime factors (both 0 for
// a value of 0 or 1, a prime returns itself in both). Candidates run 2, 3, 5,
// 7, 9, ... while the candidate does not exceed the cofactor divided by it;
// each candidate that divides is removed completely, and a cofactor above 1
// left at the end is counted as the last prime. All divisions go through one
// shared restoring divider that yields one quotient bit per cycle; each
// division runs from the sequencer's start step through the divider's bit
// steps to the sequencer's decide step. A large 32-bit prime tries about
// 32768 candidates. The input side is ready only while the sequencer is
// idle; the finished result sits in an output register so a new item can be
// taken while the result waits to be read.

module prime_factor_summary_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pfs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [pfs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // factor_sum (upper half), largest_factor (lower half)
);

  localparam int unsigned VW = pfs_pkg::VALUE_WIDTH;

  pfs_pkg::state_e   state_q, state_d;
  pfs_pkg::value_t   rest_q, rest_d;       // remaining cofactor
  pfs_pkg::value_t   cand_q, cand_d;       // current trial divisor
  pfs_pkg::value_t   sum_q, sum_d;
  pfs_pkg::value_t   largest_q, largest_d;
  logic              counted_q, counted_d; // current candidate already counted

  logic              out_valid_q, out_valid_d;
  pfs_pkg::value_t   out_largest_q, out_largest_d;
  pfs_pkg::value_t   out_sum_q, out_sum_d;

  pfs_pkg::div_req_t div_req;
  pfs_pkg::div_rsp_t div_rsp;

  pfs_pkg::value_t   cand_next;
  logic              in_take;
  logic              out_free;

  pfs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // candidate sequence 2, 3, 5, 7, 9, ...
  assign cand_next = (cand_q == VW'(2)) ? VW'(3) : cand_q + VW'(2);

  assign s_axis_tready = (state_q == pfs_pkg::ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign div_req.start    = (state_q == pfs_pkg::ST_START);
  assign div_req.dividend = rest_q;
  assign div_req.divisor  = cand_q;

  always_comb begin
    state_d       = state_q;
    rest_d        = rest_q;
    cand_d        = cand_q;
    sum_d         = sum_q;
    largest_d     = largest_q;
    counted_d     = counted_q;
    out_valid_d   = out_valid_q;
    out_largest_d = out_largest_q;
    out_sum_d     = out_sum_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pfs_pkg::ST_IDLE: begin
        if (in_take) begin
          rest_d    = s_axis_tdata[VW-1:0];
          cand_d    = VW'(2);
          sum_d     = '0;
          largest_d = '0;
          counted_d = 1'b0;
          state_d   = pfs_pkg::ST_START;
        end
      end
      pfs_pkg::ST_START: begin
        state_d = pfs_pkg::ST_WAIT;
      end
      pfs_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          state_d = pfs_pkg::ST_START;
          if (counted_q) begin
            // dividing out a repeated factor
            if (div_rsp.remainder == '0) begin
              rest_d = div_rsp.quotient;
            end else begin
              cand_d    = cand_next;
              counted_d = 1'b0;
            end
          end else if (cand_q > div_rsp.quotient) begin
            // candidate squared exceeds the cofactor
            state_d = pfs_pkg::ST_FINISH;
          end else if (div_rsp.remainder == '0) begin
            sum_d     = sum_q + cand_q;
            largest_d = cand_q;
            rest_d    = div_rsp.quotient;
            counted_d = 1'b1;
          end else begin
            cand_d = cand_next;
          end
        end
      end
      pfs_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (rest_q > VW'(1)) begin
            // leftover cofactor is itself prime
            out_largest_d = rest_q;
            out_sum_d     = sum_q + rest_q;
          end else begin
            out_largest_d = largest_q;
            out_sum_d     = sum_q;
          end
          state_d = pfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q        <= rest_d;
    cand_q        <= cand_d;
    sum_q         <= sum_d;
    largest_q     <= largest_d;
    counted_q     <= counted_d;
    out_largest_q <= out_largest_d;
    out_sum_q     <= out_sum_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pfs_pkg::OUT_TDATA_W'({out_sum_q, out_largest_q});

endmodule
